// ===== hw/rtl/u8v_pkg.sv =====
// Shared types and constants for the UTF-8 stream validator.
`timescale 1ns / 1ps

package u8v_pkg;

   localparam logic [7:0] BYTE_TERM      = 8'h00;
   localparam logic [7:0] CTRL_MAX       = 8'h1F;
   localparam logic [7:0] ASCII_MAX      = 8'h7F;
   localparam logic [7:0] BAD_LEAD_MAX   = 8'hC1;
   localparam logic [7:0] LEAD2_MAX      = 8'hDF;
   localparam logic [7:0] LEAD3_MAX      = 8'hEF;
   localparam logic [7:0] LEAD4_MAX      = 8'hF4;
   localparam logic [7:0] LEAD_E0        = 8'hE0;
   localparam logic [7:0] LEAD_ED        = 8'hED;
   localparam logic [7:0] LEAD_F0        = 8'hF0;
   localparam logic [7:0] LEAD_F4        = 8'hF4;
   localparam logic [7:0] CONT_MASK      = 8'hC0;
   localparam logic [7:0] CONT_TAG       = 8'h80;
   localparam logic [7:0] CONT_E0_MIN    = 8'hA0;
   localparam logic [7:0] CONT_ED_MAX    = 8'h9F;
   localparam logic [7:0] CONT_F0_MIN    = 8'h90;
   localparam logic [7:0] CONT_F4_MAX    = 8'h8F;

   // Extra range rule on the byte right after an E0, ED, F0 or F4 lead.
   typedef enum logic [2:0] {
      RULE_NONE = 3'd0,
      RULE_E0   = 3'd1,
      RULE_ED   = 3'd2,
      RULE_F0   = 3'd3,
      RULE_F4   = 3'd4
   } rule_type;

   typedef struct packed {
      logic [1:0] pending;
      rule_type   rule;
      logic       error_seen;
   } state_type;

endpackage

// ===== hw/rtl/utf8_stream_validator_top.sv =====
// Top level of the UTF-8 stream validator.
`timescale 1ns / 1ps

// Checks zero-terminated byte strings for well-formed UTF-8 (RFC 3629) at one
// byte per clock. Each byte transfer on req_ is held in an input register, from
// which the decoder updates the per-string state (pending continuation
// count, second-byte range rule, sticky error flag). Nonzero bytes give no
// transfer on rsp_. A zero byte ends the string: its verdict (1 = valid) is
// loaded into the result register and offered on rsp_, and the string state
// clears so the next byte starts a new string. Rejected: control bytes 01-1F,
// stray continuations, leads C0, C1 and F5-FF, overlong forms, surrogates,
// code points above U+10FFFF, and bad or missing continuation bytes. An empty
// string is valid. A terminator passes the input register and then the result
// register; throughput is one byte per cycle while rsp_stall is low. The single
// state update per byte is what bounds the rate. A held verdict stalls req_
// only when the input register is also occupied.

module utf8_stream_validator_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_req,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_res
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // string state
   u8v_pkg::state_type state_ff, state_in, state_next;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_res_ff, rsp_res_in;

   logic out_free;   // result register can take a new verdict this cycle
   logic advance;    // input register byte goes through the decoder
   logic is_term;
   logic verdict;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   u8v_decoder u_decoder (
      .byte_in    (in_byte_ff),
      .cur_state  (state_ff),
      .next_state (state_next),
      .is_term    (is_term),
      .verdict    (verdict)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_byte_req;
      end
      if (out_free) begin
         rsp_valid_in = advance && is_term;
         rsp_res_in   = verdict;
      end
      if (advance) begin
         state_in = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   // A verdict only appears after a terminator went through the decoder.
   a_verdict_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_byte_ff == u8v_pkg::BYTE_TERM))
      else $error("verdict without terminator");

   // The sticky error leaves no character in progress.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_seen |-> (state_ff.pending == 2'd0 &&
                               state_ff.rule == u8v_pkg::RULE_NONE))
      else $error("error state carries a pending character");

   // A range rule is only live on the second byte of a 3- or 4-byte form.
   a_rule_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff.rule != u8v_pkg::RULE_NONE) |-> (state_ff.pending >= 2'd2))
      else $error("range rule without a multi-byte lead");

   // The string state is clear after a terminator.
   a_clear_after_term: assert property (@(posedge clock) disable iff (reset)
      (advance && is_term) |=> (state_ff == '0))
      else $error("state not cleared after terminator");

endmodule

// ===== hw/rtl/u8v_decoder.sv =====
// Next-state and verdict logic for one string byte.
`timescale 1ns / 1ps

module u8v_decoder (
   input  logic [7:0]          byte_in,
   input  u8v_pkg::state_type  cur_state,
   output u8v_pkg::state_type  next_state,
   output logic                is_term,
   output logic                verdict
);

   logic cont_ok;

   always_comb begin
      cont_ok = ((byte_in & u8v_pkg::CONT_MASK) == u8v_pkg::CONT_TAG);
      unique case (cur_state.rule)
         u8v_pkg::RULE_E0: cont_ok = cont_ok && (byte_in >= u8v_pkg::CONT_E0_MIN);
         u8v_pkg::RULE_ED: cont_ok = cont_ok && (byte_in <= u8v_pkg::CONT_ED_MAX);
         u8v_pkg::RULE_F0: cont_ok = cont_ok && (byte_in >= u8v_pkg::CONT_F0_MIN);
         u8v_pkg::RULE_F4: cont_ok = cont_ok && (byte_in <= u8v_pkg::CONT_F4_MAX);
         default:          cont_ok = cont_ok;
      endcase
   end

   always_comb begin
      is_term    = (byte_in == u8v_pkg::BYTE_TERM);
      verdict    = !cur_state.error_seen && (cur_state.pending == 2'd0);
      next_state = cur_state;
      if (is_term) begin
         next_state = '0;
      end else if (cur_state.error_seen) begin
         next_state = cur_state;
      end else if (cur_state.pending != 2'd0) begin
         if (cont_ok) begin
            next_state.pending = cur_state.pending - 2'd1;
            next_state.rule    = u8v_pkg::RULE_NONE;
         end else begin
            next_state            = '0;
            next_state.error_seen = 1'b1;
         end
      end else if (byte_in > u8v_pkg::CTRL_MAX && byte_in <= u8v_pkg::ASCII_MAX) begin
         next_state = cur_state;
      end else if (byte_in <= u8v_pkg::BAD_LEAD_MAX) begin
         // control bytes, stray continuations, C0 and C1
         next_state            = '0;
         next_state.error_seen = 1'b1;
      end else if (byte_in <= u8v_pkg::LEAD2_MAX) begin
         next_state.pending = 2'd1;
         next_state.rule    = u8v_pkg::RULE_NONE;
      end else if (byte_in <= u8v_pkg::LEAD3_MAX) begin
         next_state.pending = 2'd2;
         next_state.rule    = (byte_in == u8v_pkg::LEAD_E0) ? u8v_pkg::RULE_E0 :
                              (byte_in == u8v_pkg::LEAD_ED) ? u8v_pkg::RULE_ED :
                                                              u8v_pkg::RULE_NONE;
      end else if (byte_in <= u8v_pkg::LEAD4_MAX) begin
         next_state.pending = 2'd3;
         next_state.rule    = (byte_in == u8v_pkg::LEAD_F0) ? u8v_pkg::RULE_F0 :
                              (byte_in == u8v_pkg::LEAD_F4) ? u8v_pkg::RULE_F4 :
                                                              u8v_pkg::RULE_NONE;
      end else begin
         next_state            = '0;
         next_state.error_seen = 1'b1;
      end
   end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the UTF-8 stream validator: directed strings, then random strings.
`timescale 1ns / 1ps

module testbench;
   import u8v_pkg::*;

   // Run shape. The hold-off and the pause fall at fixed positions in the
   // byte stream, and the calm tail (no idling on either side) covers the
   // last CALM_TAIL bytes.
   localparam int RANDOM_BYTES = 1270;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 900;
   localparam int CALM_TAIL    = 200;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int SETTLE       = 20;
   localparam int TIMEOUT_NS   = 1_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam logic [7:0] CONT_MAX = 8'hBF;

   // A table row carries a verdict typed by hand (HAND) or leaves it to
   // the decoder model (PRED). Only terminator rows ever use the verdict.
   localparam logic HAND = 1'b1;
   localparam logic PRED = 1'b0;

   typedef struct packed {
      logic [7:0] b;
      logic       typed;
      logic       typed_val;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte_req;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_valid_res;

   utf8_stream_validator_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_byte_req  (req_byte_req),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res)
   );

   // Directed strings. Hand-typed verdicts only where the answer is plain:
   // empty string, control byte, space and DEL, top lead byte, overlong
   // lead with the sticky error swallowing the next byte, and a string cut
   // off inside a character. The rest go through the decoder model.
   stim_row_type dir_rows [26] = '{
      '{BYTE_TERM, HAND, 1'b1},                              // empty string
      '{8'h01, PRED, 1'b0}, '{BYTE_TERM, HAND, 1'b0},        // control byte
      '{8'h20, PRED, 1'b0}, '{ASCII_MAX, PRED, 1'b0},
      '{BYTE_TERM, HAND, 1'b1},                              // space and DEL
      '{8'hFF, PRED, 1'b0}, '{BYTE_TERM, HAND, 1'b0},        // top lead byte
      '{8'hC1, PRED, 1'b0}, '{CONT_TAG, PRED, 1'b0},
      '{BYTE_TERM, HAND, 1'b0},                              // overlong, sticky
      '{8'hC2, PRED, 1'b0}, '{CONT_MAX, PRED, 1'b0}, '{BYTE_TERM, PRED, 1'b0},
      '{LEAD_E0, PRED, 1'b0}, '{CONT_E0_MIN, PRED, 1'b0}, '{CONT_TAG, PRED, 1'b0},
      '{BYTE_TERM, PRED, 1'b0},                              // smallest 3-byte
      '{LEAD_ED, PRED, 1'b0}, '{8'hA0, PRED, 1'b0},
      '{BYTE_TERM, PRED, 1'b0},                              // surrogate
      '{LEAD_F4, PRED, 1'b0}, '{8'h90, PRED, 1'b0},
      '{BYTE_TERM, PRED, 1'b0},                              // above U+10FFFF
      '{8'hE1, PRED, 1'b0}, '{BYTE_TERM, HAND, 1'b0}         // cut-off char
   };

   stim_row_type stim_q [$];
   logic         verdict_q [$];

   // Decoder model state, one string at a time.
   logic [1:0] dec_pending;
   rule_type   dec_rule;
   logic       dec_bad;

   int  fail_count   = 0;
   int  taken_cnt    = 0;
   int  valid_seen   = 0;
   int  invalid_seen = 0;
   int  calm_from    = 0;
   bit  calm         = 1'b0;
   bit  hold_off_go  = 1'b0;

   // ---------------------------------------------------------------------
   // Decoder model
   // ---------------------------------------------------------------------

   function automatic bit cont_in_range(logic [7:0] b, rule_type r);
      if ((b & CONT_MASK) != CONT_TAG)
         return 1'b0;
      case (r)
         RULE_E0: return b >= CONT_E0_MIN;
         RULE_ED: return b <= CONT_ED_MAX;
         RULE_F0: return b >= CONT_F0_MIN;
         RULE_F4: return b <= CONT_F4_MAX;
         default: return 1'b1;
      endcase
   endfunction

   function automatic void mark_bad();
      dec_bad     = 1'b1;
      dec_pending = 2'd0;
      dec_rule    = RULE_NONE;
   endfunction

   // Advances the model by one byte; returns 1 when the byte ends a string,
   // with the verdict in 'verdict'.
   function automatic bit decode_byte(input logic [7:0] b, output logic verdict);
      verdict = 1'b0;
      if (b == BYTE_TERM) begin
         verdict     = !dec_bad && (dec_pending == 2'd0);
         dec_pending = 2'd0;
         dec_rule    = RULE_NONE;
         dec_bad     = 1'b0;
         return 1'b1;
      end
      if (dec_bad)
         return 1'b0;
      if (dec_pending != 2'd0) begin
         if (cont_in_range(b, dec_rule)) begin
            dec_pending = dec_pending - 2'd1;
            dec_rule    = RULE_NONE;
         end else begin
            mark_bad();
         end
      end else if (b > CTRL_MAX && b <= ASCII_MAX) begin
         // single-byte character, nothing to track
      end else if (b <= BAD_LEAD_MAX) begin
         mark_bad();
      end else if (b <= LEAD2_MAX) begin
         dec_pending = 2'd1;
         dec_rule    = RULE_NONE;
      end else if (b <= LEAD3_MAX) begin
         dec_pending = 2'd2;
         dec_rule    = (b == LEAD_E0) ? RULE_E0 : (b == LEAD_ED) ? RULE_ED : RULE_NONE;
      end else if (b <= LEAD4_MAX) begin
         dec_pending = 2'd3;
         dec_rule    = (b == LEAD_F0) ? RULE_F0 : (b == LEAD_F4) ? RULE_F4 : RULE_NONE;
      end else begin
         mark_bad();
      end
      return 1'b0;
   endfunction

   function automatic void note_failure(string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("MISMATCH @%0t: %s", $realtime, what);
   endfunction

   // ---------------------------------------------------------------------
   // Random string builder
   // ---------------------------------------------------------------------

   // Continuation byte for a given rule. After a rule-bearing lead it now and
   // then picks a value right at a range border, which is where overlong
   // forms, surrogates and out-of-range code points live.
   function automatic logic [7:0] pick_cont(rule_type r);
      if (r != RULE_NONE && $urandom_range(0, 5) == 0) begin
         case ($urandom_range(0, 5))
            0:       return ASCII_MAX;
            1:       return CONT_F4_MAX;
            2:       return CONT_F0_MIN;
            3:       return CONT_ED_MAX;
            4:       return CONT_E0_MIN;
            default: return CONT_MASK;
         endcase
      end
      case (r)
         RULE_E0: return 8'($urandom_range(CONT_E0_MIN, CONT_MAX));
         RULE_ED: return 8'($urandom_range(CONT_TAG, CONT_ED_MAX));
         RULE_F0: return 8'($urandom_range(CONT_F0_MIN, CONT_MAX));
         RULE_F4: return 8'($urandom_range(CONT_TAG, CONT_F4_MAX));
         default: return 8'($urandom_range(CONT_TAG, CONT_MAX));
      endcase
   endfunction

   // Mostly well-formed strings of random characters, some with one byte
   // damaged, dropped or added; the rest pure noise.
   task automatic append_string();
      logic [7:0] s [$];
      logic [7:0] lead;
      rule_type   r;
      int         n, k, pos;
      n = $urandom_range(0, 6);
      if ($urandom_range(0, 99) < 12) begin
         for (k = 0; k < n; k++)
            s.push_back(8'($urandom_range(1, 255)));
      end else begin
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
               0: s.push_back(8'($urandom_range(8'h20, ASCII_MAX)));
               1: begin
                  s.push_back(8'($urandom_range(BAD_LEAD_MAX + 8'd1, LEAD2_MAX)));
                  s.push_back(pick_cont(RULE_NONE));
               end
               2: begin
                  if ($urandom_range(0, 2) == 0)
                     lead = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
                  else
                     lead = 8'($urandom_range(LEAD_E0, LEAD3_MAX));
                  r = (lead == LEAD_E0) ? RULE_E0 : (lead == LEAD_ED) ? RULE_ED : RULE_NONE;
                  s.push_back(lead);
                  s.push_back(pick_cont(r));
                  s.push_back(pick_cont(RULE_NONE));
               end
               default: begin
                  if ($urandom_range(0, 2) != 0)
                     lead = $urandom_range(0, 1) ? LEAD_F0 : LEAD_F4;
                  else
                     lead = 8'($urandom_range(LEAD_F0, LEAD4_MAX));
                  r = (lead == LEAD_F0) ? RULE_F0 : (lead == LEAD_F4) ? RULE_F4 : RULE_NONE;
                  s.push_back(lead);
                  s.push_back(pick_cont(r));
                  s.push_back(pick_cont(RULE_NONE));
                  s.push_back(pick_cont(RULE_NONE));
               end
            endcase
         end
         if (s.size() > 0 && $urandom_range(0, 99) < 20) begin
            pos = $urandom_range(0, s.size() - 1);
            case ($urandom_range(0, 2))
               0:       s[pos] = 8'($urandom_range(1, 255));
               1:       s.delete(pos);
               default: s.insert(pos, 8'($urandom_range(1, 255)));
            endcase
         end
      end
      foreach (s[i])
         stim_q.push_back('{s[i], PRED, 1'b0});
      stim_q.push_back('{BYTE_TERM, PRED, 1'b0});
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset and run limit
   // ---------------------------------------------------------------------

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Reset is held at the start and never asserted again.
   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Far beyond the slowest legal run (every byte behind the longest gap,
   // every verdict behind the longest stall, plus the long hold-off).
   initial begin
      #(TIMEOUT_NS);
      $display("Run timed out with %0d verdicts outstanding", verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sender: walks the byte list, with gap bursts, one long pause and a
   // calm tail. Also closes the run.
   // ---------------------------------------------------------------------

   initial begin : sender
      int idx, gap, gap_pct, n;
      req_valid    = 1'b0;
      req_byte_req = '0;
      foreach (dir_rows[i])
         stim_q.push_back(dir_rows[i]);
      while (stim_q.size() < $size(dir_rows) + RANDOM_BYTES)
         append_string();
      calm_from = stim_q.size() - CALM_TAIL;
      gap_pct   = 0;

      wait (!reset);
      @(posedge clock);
      for (idx = 0; idx < stim_q.size(); idx++) begin
         // Gap density changes every so often; zero gives idle-free stretches.
         if (idx % 150 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 15;
               default: gap_pct = 40;
            endcase
         end
         if (idx == calm_from)
            calm = 1'b1;
         // The receiver holds off for a long stretch while bytes keep coming,
         // so a held verdict backs up into the input register.
         if (idx == HOLD_AT)
            hold_off_go = 1'b1;

         gap = 0;
         if (!calm && $urandom_range(0, 99) < gap_pct)
            gap = $urandom_range(1, 18);

         if (idx == PAUSE_AT) begin
            // Sender goes quiet until every verdict owed has been taken.
            req_valid <= 1'b0;
            @(posedge clock);
            while (verdict_q.size() != 0)
               @(posedge clock);
         end else if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end

         req_valid    <= 1'b1;
         req_byte_req <= stim_q[idx].b;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
      end
      req_valid <= 1'b0;

      // Drain: wait for the last verdicts, bounded, then let the bench idle
      // to catch any stray transfer on rsp_.
      @(posedge clock);
      for (n = 0; n < DRAIN_LIMIT && verdict_q.size() != 0; n++)
         @(posedge clock);
      if (verdict_q.size() != 0)
         note_failure($sformatf("%0d verdicts never arrived", verdict_q.size()));
      repeat (SETTLE) @(posedge clock);

      $display("Run covered %0d bytes in %0d terminated strings (%0d directed bytes).",
               taken_cnt, valid_seen + invalid_seen, $size(dir_rows));
      $display("Verdicts checked: %0d valid, %0d invalid; %0d failures.",
               valid_seen, invalid_seen, fail_count);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: stall bursts at varying density, the one long hold-off, and
   // no stalls once the calm tail starts.
   // ---------------------------------------------------------------------

   initial begin : receiver
      int stall_pct, bursts, n;
      rsp_stall = 1'b0;
      stall_pct = 0;
      bursts    = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (bursts == 0) begin
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               default: stall_pct = 60;
            endcase
            bursts = 40;
         end
         bursts--;
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++)
               @(posedge clock);
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every byte transfer runs the decoder model; every verdict
   // transfer is checked against the oldest verdict owed. The byte side is
   // handled first so a same-edge verdict could still be matched.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : monitor
      logic verdict, want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (decode_byte(req_byte_req, verdict)) begin
               if (stim_q[taken_cnt].typed == HAND)
                  verdict = stim_q[taken_cnt].typed_val;
               verdict_q.push_back(verdict);
            end
            taken_cnt++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               note_failure($sformatf("verdict %b with none owed", rsp_valid_res));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_valid_res !== want)
                  note_failure($sformatf("valid_res expected %b, got %b",
                                         want, rsp_valid_res));
               if (want)
                  valid_seen++;
               else
                  invalid_seen++;
            end
         end
      end
   end

   initial begin
      dec_pending = 2'd0;
      dec_rule    = RULE_NONE;
      dec_bad     = 1'b0;
   end

endmodule

// ===== sim.f =====
hw/rtl/u8v_pkg.sv
hw/rtl/u8v_decoder.sv
hw/rtl/utf8_stream_validator_top.sv
test/testbench.sv
